@@ design/ms_pkg.sv @@
// Shared types and constants for the merge sorter.
package ms_pkg;

    localparam int KEY_W = 32;

    typedef logic signed [KEY_W-1:0] key_t;

endpackage

@@ design/ms_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/merge_sorter.sv @@
// Merge sorter top level: batch load, bottom-up merge passes, sorted emit.
//
// Keys are loaded one word per cycle while busy is low; the word with last=1
// closes the batch and starts the sort. With n keys held, the sort runs
// ceil(log2 n) merge passes between the key store and the scratch RAM; each
// pass writes one word per cycle, a rate set by the single write port of each
// RAM, with a setup state before each run pair and a check state between
// passes. The sorted words then leave one per cycle on strobe, each from a
// registered read, with last_res on the final word and dropped on every word
// of a batch that lost keys past DEPTH. The receiver cannot stall: strobe
// words must be taken as they come.
// busy is high from the cycle after the closing word until the last read
// is issued; a new batch may start loading while the final word is shown.
module merge_sorter #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [31:0]       key,
    input  logic                     last,
    output logic                     strobe,
    output logic signed [31:0]       sorted_key,
    output logic                     last_res,
    output logic                     dropped
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_MERGE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          src_sel_reg, src_sel_next;   // 0: key store is source
    logic [PW-1:0] width_reg, width_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] a_reg, a_next;
    logic [PW-1:0] b_reg, b_next;
    logic [PW-1:0] k_reg, k_next;
    logic [PW-1:0] mid_reg, mid_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [CW-1:0] e_reg, e_next;
    logic          strobe_reg, strobe_next;
    logic          last_res_reg, last_res_next;
    logic          dropped_reg, dropped_next;

    logic [AW-1:0]     raddr_a, raddr_b;
    logic              sto_we, scr_we;
    logic [AW-1:0]     sto_waddr, scr_waddr;
    ms_pkg::key_t      sto_wdata, scr_wdata;
    ms_pkg::key_t      sto_rd_a, sto_rd_b, scr_rd_a, scr_rd_b;
    ms_pkg::key_t      src_a, src_b, merge_word;

    logic [PW-1:0] n_ext;
    logic [PW-1:0] run_mid, run_hi, lo_step;
    logic          take_a;
    logic          accept;

    ms_ram #(.WIDTH(ms_pkg::KEY_W), .DEPTH(DEPTH)) u_key_store (
        .clk     (clk),
        .we      (sto_we),
        .waddr   (sto_waddr),
        .wdata   (sto_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (sto_rd_a),
        .rdata_b (sto_rd_b)
    );

    ms_ram #(.WIDTH(ms_pkg::KEY_W), .DEPTH(DEPTH)) u_merge_scratch (
        .clk     (clk),
        .we      (scr_we),
        .waddr   (scr_waddr),
        .wdata   (scr_wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (scr_rd_a),
        .rdata_b (scr_rd_b)
    );

    assign accept = start && !busy;
    assign n_ext  = PW'(count_reg);

    assign src_a = src_sel_reg ? scr_rd_a : sto_rd_a;
    assign src_b = src_sel_reg ? scr_rd_b : sto_rd_b;

    // run boundaries for the pair starting at lo
    always_comb
    begin
        run_mid = lo_reg + width_reg;
        run_hi  = lo_reg + (width_reg << 1);
        if (run_mid > n_ext)
        begin
            run_mid = n_ext;
        end
        if (run_hi > n_ext)
        begin
            run_hi = n_ext;
        end
        lo_step = lo_reg + (width_reg << 1);
    end

    // left run wins on ties
    assign take_a = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (src_a <= src_b));
    assign merge_word = take_a ? src_a : src_b;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        src_sel_next  = src_sel_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        e_next        = e_reg;
        strobe_next   = 1'b0;
        last_res_next = last_res_reg;
        dropped_next  = dropped_reg;

        raddr_a   = a_reg[AW-1:0];
        raddr_b   = b_reg[AW-1:0];
        sto_we    = 1'b0;
        scr_we    = 1'b0;
        sto_waddr = k_reg[AW-1:0];
        scr_waddr = k_reg[AW-1:0];
        sto_wdata = merge_word;
        scr_wdata = merge_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        sto_we     = 1'b1;
                        sto_waddr  = count_reg[AW-1:0];
                        sto_wdata  = key;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        src_sel_next = 1'b0;
                        width_next   = PW'(1);
                        lo_next      = '0;
                        state_next   = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                if (width_reg >= n_ext)
                begin
                    e_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                raddr_a    = lo_reg[AW-1:0];
                raddr_b    = run_mid[AW-1:0];
                a_next     = lo_reg;
                b_next     = run_mid;
                k_next     = lo_reg;
                mid_next   = run_mid;
                hi_next    = run_hi;
                state_next = ST_MERGE;
            end

            ST_MERGE:
            begin
                sto_we = src_sel_reg;
                scr_we = !src_sel_reg;
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                // next words come back next cycle from the advanced pointers
                raddr_a = a_next[AW-1:0];
                raddr_b = b_next[AW-1:0];
                k_next  = k_reg + 1'b1;
                if (k_next == hi_reg)
                begin
                    if (lo_step >= n_ext)
                    begin
                        width_next   = width_reg << 1;
                        src_sel_next = !src_sel_reg;
                        lo_next      = '0;
                        state_next   = ST_CHECK;
                    end
                    else
                    begin
                        lo_next    = lo_step;
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_EMIT:
            begin
                raddr_a       = e_reg[AW-1:0];
                strobe_next   = 1'b1;
                dropped_next  = ovf_reg;
                last_res_next = (e_reg + 1'b1) == count_reg;
                e_next        = e_reg + 1'b1;
                if ((e_reg + 1'b1) == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            src_sel_reg  <= 1'b0;
            width_reg    <= '0;
            lo_reg       <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            k_reg        <= '0;
            mid_reg      <= '0;
            hi_reg       <= '0;
            e_reg        <= '0;
            strobe_reg   <= 1'b0;
            last_res_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            src_sel_reg  <= src_sel_next;
            width_reg    <= width_next;
            lo_reg       <= lo_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            k_reg        <= k_next;
            mid_reg      <= mid_next;
            hi_reg       <= hi_next;
            e_reg        <= e_next;
            strobe_reg   <= strobe_next;
            last_res_reg <= last_res_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign sorted_key = src_a;
    assign last_res   = last_res_reg;
    assign dropped    = dropped_reg;

endmodule

@@ tb/tb_merge_sorter.sv @@
// Self-checking testbench for merge_sorter: batch stimulus, sorted-word scoreboard.

// Holds the keys of the open batch and the sorted words still to come.
class sort_scoreboard;

    localparam int CAPACITY = 64;

    typedef struct {
        ms_pkg::key_t value;
        bit           is_last;
        bit           lost_keys;
    } sorted_word_t;

    ms_pkg::key_t held[CAPACITY];
    int           held_count;
    bit           batch_overflow;
    sorted_word_t pending_words[$];
    int           mismatches;

    function new();
        held_count     = 0;
        batch_overflow = 0;
        mismatches     = 0;
    endfunction

    function int pending();
        return pending_words.size();
    endfunction

    // Bottom-up merge passes; left run wins on equal keys.
    function void close_batch();
        ms_pkg::key_t src[CAPACITY];
        ms_pkg::key_t dst[CAPACITY];
        sorted_word_t w;
        int run, lo, mid, hi, a, b, k, i;
        src = held;
        dst = held;
        for (run = 1; run < held_count; run = run * 2)
        begin
            for (lo = 0; lo < held_count; lo = lo + 2 * run)
            begin
                mid = (lo + run < held_count) ? lo + run : held_count;
                hi  = (lo + 2 * run < held_count) ? lo + 2 * run : held_count;
                a = lo;
                b = mid;
                k = lo;
                while (a < mid || b < hi)
                begin
                    if (b >= hi || (a < mid && src[a] <= src[b]))
                    begin
                        dst[k] = src[a];
                        a++;
                    end
                    else
                    begin
                        dst[k] = src[b];
                        b++;
                    end
                    k++;
                end
            end
            src = dst;
        end
        for (i = 0; i < held_count; i++)
        begin
            w.value     = src[i];
            w.is_last   = (i == held_count - 1);
            w.lost_keys = batch_overflow;
            pending_words.push_back(w);
        end
        held_count     = 0;
        batch_overflow = 0;
    endfunction

    function void note_key(ms_pkg::key_t k, bit is_last);
        if (held_count < CAPACITY)
        begin
            held[held_count] = k;
            held_count++;
        end
        else
            batch_overflow = 1;
        if (is_last)
            close_batch();
    endfunction

    function void check_word(ms_pkg::key_t k, bit is_last, bit lost_keys);
        sorted_word_t w;
        if (pending_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: key %0d last %0b dropped %0b",
                         k, is_last, lost_keys);
            return;
        end
        w = pending_words.pop_front();
        if (w.value !== k || w.is_last !== is_last || w.lost_keys !== lost_keys)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"word mismatch: expected key %0d last %0b dropped %0b, ",
                          "got key %0d last %0b dropped %0b"},
                         w.value, w.is_last, w.lost_keys, k, is_last, lost_keys);
        end
    endfunction

endclass

module tb_merge_sorter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SORT_DEPTH   = 64;
    localparam int ITEM_TARGET  = 410;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int GAP_PERCENT  = 20;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    ms_pkg::key_t key;
    logic         last;
    logic         strobe;
    ms_pkg::key_t sorted_key;
    logic         last_res;
    logic         dropped;

    sort_scoreboard sb;
    int             items_sent;
    int             stall_cycles;
    bit             calm;

    merge_sorter #(
        .DEPTH(SORT_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .key        (key),
        .last       (last),
        .strobe     (strobe),
        .sorted_key (sorted_key),
        .last_res   (last_res),
        .dropped    (dropped)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_key(key, last);
            if (strobe)
                sb.check_word(sorted_key, last_res, dropped);
        end
    end

    // Cycles with no word moving in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_merge_sorter: errors");
            $finish;
        end
    end

    function automatic ms_pkg::key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return ms_pkg::key_t'($signed($urandom_range(0, 7)) - 4);
        else if (r < 32)
            return {1'b1, 31'h0};
        else if (r < 39)
            return {1'b0, {31{1'b1}}};
        else
            return ms_pkg::key_t'($urandom);
    endfunction

    task automatic send_word(input ms_pkg::key_t k, input bit is_last);
        // start drops low now and then between words, but never during the calm stretch
        if (!calm && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        key   <= k;
        last  <= is_last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        calm = (items_sent >= 150 && items_sent < 260);
    endtask

    task automatic send_batch(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_word(pick_key(), i == count - 1);
    endtask

    initial
    begin
        ms_pkg::key_t mixed[8];
        ms_pkg::key_t equal_run[5];
        int           batch_no;
        int           size;
        int           r;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        key          = '0;
        last         = 1'b0;
        items_sent   = 0;
        stall_cycles = 0;
        calm         = 0;
        sb           = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-key batches come back unchanged, then a two-key batch is sorted
        send_word({1'b0, {31{1'b1}}}, 1'b1);
        send_word({1'b1, 31'h0}, 1'b1);
        send_word(ms_pkg::key_t'(5), 1'b0);
        send_word(ms_pkg::key_t'(-3), 1'b1);
        mixed = '{{1'b0, {31{1'b1}}}, {1'b1, 31'h0}, 32'sd0, -32'sd1,
                  32'sd1, {1'b1, 31'h0}, {1'b0, {31{1'b1}}}, 32'sd0};
        foreach (mixed[i])
            send_word(mixed[i], i == 7);
        equal_run = '{32'sd3, 32'sd3, 32'sd3, -32'sd7, 32'sd3};
        foreach (equal_run[i])
            send_word(equal_run[i], i == 4);

        batch_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (batch_no == 1)
                size = SORT_DEPTH + 1;          // the closing key itself is dropped
            else if (batch_no == 4)
                size = SORT_DEPTH;
            else if (batch_no == 7)
                size = SORT_DEPTH + $urandom_range(2, 8);
            else if (r < 70)
                size = $urandom_range(1, 16);
            else if (r < 90)
                size = $urandom_range(17, SORT_DEPTH - 1);
            else if (r < 95)
                size = SORT_DEPTH;
            else
                size = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
            send_batch(size);
            batch_no++;
        end
        @(negedge clk);
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_merge_sorter: clean");
        else
            $display("tb_merge_sorter: errors");
        $finish;
    end

endmodule
